/* rtl/lsf_pkg.sv */
// shared types and constants for the least-squares line fit
`default_nettype none

package lsf_pkg;

    localparam int XY_W           = 24;
    localparam int CNT_W          = 13;
    localparam int SUM_W          = 36;
    localparam int SQ_W           = 60;
    localparam int A_W            = 60;
    localparam int B_W            = 36;
    localparam int ACC_W          = 98;
    localparam int NUM_W          = 114;
    localparam int DEN_W          = 72;
    localparam int Q_W            = 33;
    localparam int OUT_W          = 32;
    localparam int ITER_W         = $clog2(NUM_W);
    localparam int SLOPE_SHIFT    = 16;
    localparam int ICPT_SHIFT     = 4;
    localparam int MAX_POINTS_DEF = 4096;

    typedef enum logic [1:0] {
        FIT_OK        = 2'd0,
        FIT_SINGULAR  = 2'd1,
        FIT_SATURATED = 2'd2,
        FIT_TOO_MANY  = 2'd3
    } t_fit_status;

    typedef enum logic [1:0] {
        OP_MAC_NEW,
        OP_MAC_SUB,
        OP_DIV
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_unit_rsp;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_RND,
        U_FIN
    } t_unit_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_XY,
        S_DEN_A,
        S_DEN_B,
        S_NS_A,
        S_NS_B,
        S_DIV_S,
        S_NI_A,
        S_NI_B,
        S_DIV_I,
        S_OUT
    } t_seq_state;

endpackage

`default_nettype wire

/* rtl/least_squares_line_fit.sv */
// least-squares straight-line fit over a stream of points
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_stall   x_coord, y_coord, last_point
//  out      source     o_out_valid / i_out_stall slope, intercept, fit_status, points_used
//
// each point is accepted, then x*x and x*y go through one 24x24 multiplier
// a closing point then adds six shift-add products and two restoring divides
// (only the first two products when singular, none on too many points), all in the shared unit
// synchronous active-low reset clears the sequencer, sums and output valid
// a stalled result waits in the output register while the next set is taken in
`default_nettype none

module least_squares_line_fit #(
    parameter int MAX_POINTS = lsf_pkg::MAX_POINTS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire signed [lsf_pkg::XY_W-1:0]    i_x_coord,
    input  wire signed [lsf_pkg::XY_W-1:0]    i_y_coord,
    input  wire                               i_last_point,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic signed [lsf_pkg::OUT_W-1:0]  o_slope,
    output logic signed [lsf_pkg::OUT_W-1:0]  o_intercept,
    output logic       [1:0]                  o_fit_status,
    output logic       [lsf_pkg::CNT_W-1:0]   o_points_used
);
    import lsf_pkg::*;

    t_seq_state                 r_state;
    t_seq_state                 n_state;
    logic signed [XY_W-1:0]     r_x;
    logic signed [XY_W-1:0]     r_y;
    logic                       r_last;
    logic                       r_take;
    logic [CNT_W-1:0]           r_count;
    logic signed [SUM_W-1:0]    r_sx;
    logic signed [SUM_W-1:0]    r_sy;
    logic signed [SQ_W-1:0]     r_sxx;
    logic signed [SQ_W-1:0]     r_sxy;
    logic                       r_ovf;
    logic [DEN_W-1:0]           r_den;
    logic [OUT_W-1:0]           r_slope;
    logic [OUT_W-1:0]           r_icpt;
    t_fit_status                r_status;
    logic                       r_sat;
    logic                       r_wait;
    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out_slope;
    logic [OUT_W-1:0]           r_out_icpt;
    t_fit_status                r_out_status;
    logic [CNT_W-1:0]           r_out_points;

    logic signed [XY_W-1:0]     mul_b;
    logic signed [2*XY_W-1:0]   mul_p;
    logic                       take;
    logic                       out_free;
    logic                       op_state;
    t_unit_req                  u_req;
    t_unit_rsp                  u_rsp;
    logic signed [A_W-1:0]      u_a;
    logic signed [B_W-1:0]      u_b;
    logic signed [NUM_W-1:0]    u_num;
    logic signed [ACC_W-1:0]    u_acc;
    logic [OUT_W-1:0]           u_quot;
    logic                       den_bad;

    assign mul_b    = (r_state == S_XY) ? r_y : r_x;
    assign mul_p    = r_x * mul_b;
    assign take     = r_count < CNT_W'(MAX_POINTS);
    assign out_free = ~r_out_valid | ~i_out_stall;
    assign den_bad  = u_acc[ACC_W-1] | (u_acc == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SQ;
            S_SQ:    n_state = S_XY;
            S_XY: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_ovf) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DEN_A;
                end
            end
            S_DEN_A: if (u_rsp.done) n_state = S_DEN_B;
            S_DEN_B: if (u_rsp.done) n_state = den_bad ? S_OUT : S_NS_A;
            S_NS_A:  if (u_rsp.done) n_state = S_NS_B;
            S_NS_B:  if (u_rsp.done) n_state = S_DIV_S;
            S_DIV_S: if (u_rsp.done) n_state = S_NI_A;
            S_NI_A:  if (u_rsp.done) n_state = S_NI_B;
            S_NI_B:  if (u_rsp.done) n_state = S_DIV_I;
            S_DIV_I: if (u_rsp.done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        op_state   = 1'b0;
        u_req.op   = OP_MAC_NEW;
        u_a        = '0;
        u_b        = '0;
        u_num      = '0;
        case (r_state)
            S_DEN_A: begin
                op_state = 1'b1;
                u_a      = r_sxx;
                u_b      = B_W'(r_count);
            end
            S_DEN_B: begin
                op_state = 1'b1;
                u_req.op = OP_MAC_SUB;
                u_a      = A_W'(r_sx);
                u_b      = r_sx;
            end
            S_NS_A: begin
                op_state = 1'b1;
                u_a      = r_sxy;
                u_b      = B_W'(r_count);
            end
            S_NS_B: begin
                op_state = 1'b1;
                u_req.op = OP_MAC_SUB;
                u_a      = A_W'(r_sy);
                u_b      = r_sx;
            end
            S_DIV_S: begin
                op_state = 1'b1;
                u_req.op = OP_DIV;
                u_num    = NUM_W'(u_acc) <<< SLOPE_SHIFT;
            end
            S_NI_A: begin
                op_state = 1'b1;
                u_a      = r_sxx;
                u_b      = r_sy[B_W-1:0];
            end
            S_NI_B: begin
                op_state = 1'b1;
                u_req.op = OP_MAC_SUB;
                u_a      = r_sxy;
                u_b      = r_sx;
            end
            S_DIV_I: begin
                op_state = 1'b1;
                u_req.op = OP_DIV;
                u_num    = NUM_W'(u_acc) <<< ICPT_SHIFT;
            end
            default: begin
                op_state = 1'b0;
            end
        endcase
        u_req.start = op_state & ~r_wait;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxx       <= '0;
            r_sxy       <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (u_rsp.done) begin
                r_wait <= 1'b0;
            end else if (u_req.start) begin
                r_wait <= 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_SQ) begin
                if (take) begin
                    r_count <= r_count + CNT_W'(1);
                    r_sx    <= r_sx + SUM_W'(r_x);
                    r_sy    <= r_sy + SUM_W'(r_y);
                    r_sxx   <= r_sxx + SQ_W'(mul_p);
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (r_state == S_XY && r_take) begin
                r_sxy <= r_sxy + SQ_W'(mul_p);
            end else if (r_state == S_OUT && out_free) begin
                r_count <= '0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_sxx   <= '0;
                r_sxy   <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_x    <= i_x_coord;
            r_y    <= i_y_coord;
            r_last <= i_last_point;
        end
        if (r_state == S_SQ) begin
            r_take <= take;
        end
        if (r_state == S_XY && r_last && r_ovf) begin
            r_slope  <= '0;
            r_icpt   <= '0;
            r_status <= FIT_TOO_MANY;
        end
        if (r_state == S_DEN_B && u_rsp.done) begin
            r_sat <= 1'b0;
            if (den_bad) begin
                r_slope  <= '0;
                r_icpt   <= '0;
                r_status <= FIT_SINGULAR;
            end else begin
                r_den <= u_acc[DEN_W-1:0];
            end
        end
        if (r_state == S_DIV_S && u_rsp.done) begin
            r_slope <= u_quot;
            r_sat   <= u_rsp.sat;
        end
        if (r_state == S_DIV_I && u_rsp.done) begin
            r_icpt   <= u_quot;
            r_status <= (r_sat | u_rsp.sat) ? FIT_SATURATED : FIT_OK;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_slope  <= r_slope;
            r_out_icpt   <= r_icpt;
            r_out_status <= r_status;
            r_out_points <= r_count;
        end
    end

    lsf_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .i_a     (u_a),
        .i_b     (u_b),
        .i_num   (u_num),
        .i_den   (r_den),
        .o_rsp   (u_rsp),
        .o_acc   (u_acc),
        .o_quot  (u_quot)
    );

    assign o_out_valid   = r_out_valid;
    assign o_slope       = r_out_slope;
    assign o_intercept   = r_out_icpt;
    assign o_fit_status  = r_out_status;
    assign o_points_used = r_out_points;

endmodule

`default_nettype wire

/* rtl/lsf_unit.sv */
// shared shift-add multiply-accumulate and restoring divide unit
`default_nettype none

module lsf_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  lsf_pkg::t_unit_req                i_req,
    input  wire signed [lsf_pkg::A_W-1:0]     i_a,
    input  wire signed [lsf_pkg::B_W-1:0]     i_b,
    input  wire signed [lsf_pkg::NUM_W-1:0]   i_num,
    input  wire        [lsf_pkg::DEN_W-1:0]   i_den,
    output lsf_pkg::t_unit_rsp                o_rsp,
    output logic signed [lsf_pkg::ACC_W-1:0]  o_acc,
    output logic       [lsf_pkg::OUT_W-1:0]   o_quot
);
    import lsf_pkg::*;

    t_unit_state        r_state;
    t_unit_state        n_state;
    logic [ITER_W-1:0]  r_cnt;
    logic [ACC_W-1:0]   r_ash;
    logic [B_W-1:0]     r_bsh;
    logic               r_neg;
    logic [ACC_W-1:0]   r_acc;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [Q_W-1:0]     r_q;
    logic               r_qovf;
    logic               r_qneg;
    logic [Q_W:0]       r_q1;

    logic [A_W-1:0]     a_mag;
    logic [B_W-1:0]     b_mag;
    logic [NUM_W-1:0]   num_mag;
    logic [ACC_W-1:0]   add_x;
    logic [ACC_W-1:0]   add_y;
    logic               add_ci;
    logic [ACC_W-1:0]   add_s;
    logic               ge;
    logic [Q_W:0]       limit;
    logic               sat;

    assign a_mag   = i_a[A_W-1] ? (A_W'(~i_a) + A_W'(1)) : A_W'(i_a);
    assign b_mag   = i_b[B_W-1] ? (B_W'(~i_b) + B_W'(1)) : B_W'(i_b);
    assign num_mag = i_num[NUM_W-1] ? (NUM_W'(~i_num) + NUM_W'(1)) : NUM_W'(i_num);

    // the one wide adder, shared by multiply steps, divide steps and rounding
    always_comb begin
        add_x  = '0;
        add_y  = '0;
        add_ci = 1'b0;
        case (r_state)
            U_MUL: begin
                add_x  = r_acc;
                add_y  = r_bsh[0] ? (r_neg ? ~r_ash : r_ash) : '0;
                add_ci = r_neg & r_bsh[0];
            end
            U_DIV: begin
                add_x  = ACC_W'({r_rem, r_num[NUM_W-1]});
                add_y  = ~ACC_W'(r_den);
                add_ci = 1'b1;
            end
            U_RND: begin
                add_x  = ACC_W'({r_rem, 1'b0});
                add_y  = ~ACC_W'(r_den);
                add_ci = 1'b1;
            end
            default: begin
                add_x  = '0;
            end
        endcase
    end

    assign add_s = add_x + add_y + ACC_W'(add_ci);
    assign ge    = ~add_s[ACC_W-1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.op == OP_DIV) ? U_DIV : U_MUL;
                end
            end
            U_MUL: begin
                if (r_cnt == ITER_W'(B_W - 1)) begin
                    n_state = U_FIN;
                end
            end
            U_DIV: begin
                if (r_cnt == ITER_W'(NUM_W - 1)) begin
                    n_state = U_RND;
                end
            end
            U_RND: n_state = U_FIN;
            U_FIN: n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    r_cnt <= '0;
                    if (i_req.op == OP_DIV) begin
                        r_num  <= num_mag;
                        r_qneg <= i_num[NUM_W-1];
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_qovf <= 1'b0;
                        r_den  <= i_den;
                    end else begin
                        r_ash <= ACC_W'(a_mag);
                        r_bsh <= b_mag;
                        r_neg <= i_a[A_W-1] ^ i_b[B_W-1] ^ (i_req.op == OP_MAC_SUB);
                        if (i_req.op == OP_MAC_NEW) begin
                            r_acc <= '0;
                        end
                    end
                end
            end
            U_MUL: begin
                if (r_bsh[0]) begin
                    r_acc <= add_s;
                end
                r_ash <= {r_ash[ACC_W-2:0], 1'b0};
                r_bsh <= {1'b0, r_bsh[B_W-1:1]};
                r_cnt <= r_cnt + ITER_W'(1);
            end
            U_DIV: begin
                if (ge) begin
                    r_rem <= add_s[DEN_W-1:0];
                end else begin
                    r_rem <= {r_rem[DEN_W-2:0], r_num[NUM_W-1]};
                end
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_q    <= {r_q[Q_W-2:0], ge};
                r_qovf <= r_qovf | r_q[Q_W-1];
                r_cnt  <= r_cnt + ITER_W'(1);
            end
            U_RND: begin
                r_q1 <= {1'b0, r_q} + (Q_W+1)'(ge);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // rounded quotient, clamped to the signed output range
    always_comb begin
        limit = r_qneg ? (Q_W+1)'(64'd1 << (OUT_W - 1))
                       : (Q_W+1)'((64'd1 << (OUT_W - 1)) - 64'd1);
        sat   = r_qovf | (r_q1 > limit);
        if (sat) begin
            o_quot = r_qneg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else if (r_qneg) begin
            o_quot = OUT_W'(~r_q1[OUT_W-1:0]) + OUT_W'(1);
        end else begin
            o_quot = r_q1[OUT_W-1:0];
        end
        o_rsp.done = (r_state == U_FIN);
        o_rsp.sat  = sat;
        o_acc      = r_acc;
    end

endmodule

`default_nettype wire

/* rtl/lsf_checker.sv */
// port-level checks for the line fit, bound to the top level
`default_nettype none

module lsf_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              o_in_stall,
    input wire                              o_out_valid,
    input wire                              i_out_stall,
    input wire [lsf_pkg::OUT_W-1:0]         o_slope,
    input wire [lsf_pkg::OUT_W-1:0]         o_intercept,
    input wire [1:0]                        o_fit_status,
    input wire [lsf_pkg::CNT_W-1:0]         o_points_used
);
    import lsf_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // each accepted point sets the input stall, so points are never taken back to back
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken on back-to-back cycles");

    // too many points and singular fits carry zero line parameters
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_fit_status == FIT_TOO_MANY || o_fit_status == FIT_SINGULAR)
        |-> o_slope == '0 && o_intercept == '0)
        else $error("nonzero line on failed fit");

    // every set holds at least its closing point and never more than the cap
    a_points_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_points_used != '0 && o_points_used <= CNT_W'(MAX_POINTS_DEF))
        else $error("point count out of range");

endmodule

bind least_squares_line_fit lsf_checker u_lsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_slope       (o_slope),
    .o_intercept   (o_intercept),
    .o_fit_status  (o_fit_status),
    .o_points_used (o_points_used)
);

`default_nettype wire

/* tb/least_squares_line_fit_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the least-squares line fit: point sets in, fitted lines checked

module least_squares_line_fit_tb;
    import lsf_pkg::*;

    localparam int MAX_PTS        = MAX_POINTS_DEF;
    localparam int RANDOM_POINTS  = 1590;
    localparam int LONG_HOLD      = 2000;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int SETTLE_CYCLES  = 1000;
    localparam int WIDE           = 130;

    localparam logic signed [XY_W-1:0] XY_MIN = {1'b1, {(XY_W-1){1'b0}}};
    localparam logic signed [XY_W-1:0] XY_MAX = {1'b0, {(XY_W-1){1'b1}}};

    typedef struct {
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] intercept;
        t_fit_status             status;
        logic [CNT_W-1:0]        used;
    } t_line_fit;

    typedef enum int {
        PTS_UNIFORM,
        PTS_NEAR_ORIGIN,
        PTS_ON_LINE,
        PTS_SAME_X,
        PTS_STEEP,
        PTS_CORNERS
    } t_point_mix;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic signed [XY_W-1:0]   i_x_coord    = '0;
    logic signed [XY_W-1:0]   i_y_coord    = '0;
    logic                     i_last_point = 1'b0;
    logic                     i_out_stall  = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [OUT_W-1:0]  o_slope;
    logic signed [OUT_W-1:0]  o_intercept;
    logic [1:0]               o_fit_status;
    logic [CNT_W-1:0]         o_points_used;

    logic [CNT_W-1:0]         fit_count    = '0;
    logic signed [SUM_W-1:0]  fit_sx       = '0;
    logic signed [SUM_W-1:0]  fit_sy       = '0;
    logic [SQ_W-1:0]          fit_sxx      = '0;
    logic signed [A_W-1:0]    fit_sxy      = '0;
    bit                       fit_overflow = 1'b0;

    t_line_fit                expected_fits[$];
    t_line_fit                oldest_fit;
    int                       points_sent  = 0;
    int                       mismatches   = 0;
    int                       quiet_cycles = 0;
    int                       out_wait     = 0;
    int                       hold_left    = 0;
    int                       hold_asked   = 0;
    int                       hold_given   = 0;
    bit                       in_idle_on   = 1'b1;
    bit                       out_idle_on  = 1'b1;

    least_squares_line_fit #(
        .MAX_POINTS    (MAX_PTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_last_point  (i_last_point),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_slope       (o_slope),
        .o_intercept   (o_intercept),
        .o_fit_status  (o_fit_status),
        .o_points_used (o_points_used)
    );

    always #2 i_clk = ~i_clk;

    // signed quotient rounded half away from zero, clamped to 32 bits; msb flags the clamp
    function automatic logic [OUT_W:0] round_quotient(input logic signed [WIDE-1:0] num,
                                                      input logic signed [WIDE-1:0] den);
        logic signed [WIDE-1:0] mag;
        logic signed [WIDE-1:0] quo;
        logic signed [WIDE-1:0] rem;
        logic signed [WIDE-1:0] lim;
        logic                   neg;
        logic                   sat;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = mag / den;
        rem = mag % den;
        if ((rem <<< 1) >= den) begin
            quo = quo + 1;
        end
        lim = neg ? WIDE'(64'sh8000_0000) : WIDE'(64'sh7FFF_FFFF);
        sat = quo > lim;
        if (sat) begin
            quo = lim;
        end
        if (neg) begin
            quo = -quo;
        end
        return {sat, quo[OUT_W-1:0]};
    endfunction

    task automatic fold_point(input logic signed [XY_W-1:0] x, input logic signed [XY_W-1:0] y,
                              input bit last);
        logic signed [63:0]     xl;
        logic signed [63:0]     yl;
        logic signed [63:0]     sq;
        logic signed [63:0]     xy;
        logic signed [WIDE-1:0] n;
        logic signed [WIDE-1:0] ax;
        logic signed [WIDE-1:0] ay;
        logic signed [WIDE-1:0] axx;
        logic signed [WIDE-1:0] axy;
        logic signed [WIDE-1:0] den;
        logic signed [WIDE-1:0] num_s;
        logic signed [WIDE-1:0] num_i;
        logic [OUT_W:0]         qs;
        logic [OUT_W:0]         qi;
        t_line_fit              fit;
        xl = 64'(x);
        yl = 64'(y);
        if (fit_count >= MAX_PTS) begin
            fit_overflow = 1'b1;
        end else begin
            sq        = xl * xl;
            xy        = xl * yl;
            fit_count = fit_count + 1'b1;
            fit_sx    = fit_sx + SUM_W'(x);
            fit_sy    = fit_sy + SUM_W'(y);
            fit_sxx   = fit_sxx + sq[SQ_W-1:0];
            fit_sxy   = fit_sxy + xy[A_W-1:0];
        end
        if (last) begin
            fit.slope     = '0;
            fit.intercept = '0;
            fit.used      = fit_count;
            if (fit_overflow) begin
                fit.status = FIT_TOO_MANY;
            end else begin
                n   = WIDE'(fit_count);
                ax  = WIDE'(fit_sx);
                ay  = WIDE'(fit_sy);
                axx = WIDE'(fit_sxx);
                axy = WIDE'(fit_sxy);
                den = n * axx - ax * ax;
                if (den <= 0) begin
                    fit.status = FIT_SINGULAR;
                end else begin
                    num_s         = (n * axy - ax * ay) <<< SLOPE_SHIFT;
                    num_i         = (ay * axx - ax * axy) <<< ICPT_SHIFT;
                    qs            = round_quotient(num_s, den);
                    qi            = round_quotient(num_i, den);
                    fit.slope     = qs[OUT_W-1:0];
                    fit.intercept = qi[OUT_W-1:0];
                    fit.status    = (qs[OUT_W] || qi[OUT_W]) ? FIT_SATURATED : FIT_OK;
                end
            end
            expected_fits.insert(expected_fits.size(), fit);
            fit_count    = '0;
            fit_sx       = '0;
            fit_sy       = '0;
            fit_sxx      = '0;
            fit_sxy      = '0;
            fit_overflow = 1'b0;
        end
    endtask

    task automatic send_point(input logic signed [XY_W-1:0] x, input logic signed [XY_W-1:0] y,
                              input bit last);
        int gap;
        i_in_valid   <= 1'b1;
        i_x_coord    <= x;
        i_y_coord    <= y;
        i_last_point <= last;
        do @(posedge i_clk); while (o_in_stall);
        fold_point(x, y, last);
        points_sent++;
        gap = in_idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_in_valid   <= 1'b0;
            i_x_coord    <= XY_W'($urandom);
            i_y_coord    <= XY_W'($urandom);
            i_last_point <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_fits();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_fits.size() != 0);
    endtask

    task automatic set_idling(input bit on);
        in_idle_on = on;
        out_idle_on <= on;
    endtask

    function automatic logic signed [XY_W-1:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return XY_MIN;
            1:       return XY_MAX;
            2:       return '0;
            3:       return '1;
            default: return XY_W'(1);
        endcase
    endfunction

    task automatic send_point_set(input t_point_mix mix, input int count);
        int                     anchor_x;
        int                     anchor_y;
        int                     gain;
        int                     xi;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        anchor_x = $urandom_range(0, 2**21) - 2**20;
        anchor_y = $urandom_range(0, 2**21) - 2**20;
        gain     = $urandom_range(0, 6) - 3;
        for (int i = 0; i < count; i++) begin
            case (mix)
                PTS_UNIFORM: begin
                    x = XY_W'($urandom);
                    y = XY_W'($urandom);
                end
                PTS_NEAR_ORIGIN: begin
                    x = XY_W'($urandom_range(0, 8192) - 4096);
                    y = XY_W'($urandom_range(0, 8192) - 4096);
                end
                PTS_ON_LINE: begin
                    xi = $urandom_range(0, 2**21) - 2**20;
                    x  = XY_W'(xi);
                    y  = XY_W'(gain * xi + anchor_y);
                end
                PTS_SAME_X: begin
                    x = XY_W'(anchor_x);
                    y = XY_W'($urandom);
                end
                PTS_STEEP: begin
                    x = XY_W'(anchor_x + $urandom_range(0, 1));
                    y = XY_W'($urandom);
                end
                default: begin
                    x = corner_value();
                    y = corner_value();
                end
            endcase
            send_point(x, y, i == count - 1);
        end
    endtask

    task automatic test_singular_sets();
        send_point(XY_MIN, XY_MAX, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(0, 0, 1'b1);
        send_point(XY_MAX, XY_MIN, 1'b0);
        send_point(XY_MAX, XY_MAX, 1'b0);
        send_point(XY_MAX, 0, 1'b1);
        wait_for_fits();
    endtask

    task automatic test_rounding_ties();
        send_point(0, 0, 1'b0);
        send_point(131072, 1, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(131072, -1, 1'b1);
        send_point(XY_MIN, XY_MIN, 1'b0);
        send_point(XY_MAX, XY_MAX, 1'b1);
        send_point(XY_MIN, XY_MAX, 1'b0);
        send_point(XY_MAX, XY_MIN, 1'b1);
        wait_for_fits();
    endtask

    task automatic test_saturation();
        send_point(0, XY_MIN, 1'b0);
        send_point(1, XY_MAX, 1'b1);
        send_point(0, XY_MAX, 1'b0);
        send_point(1, XY_MIN, 1'b1);
        send_point(8388351, 0, 1'b0);
        send_point(XY_MAX, 4194304, 1'b1);
        wait_for_fits();
    endtask

    task automatic test_output_hold();
        set_idling(1'b1);
        hold_asked <= hold_asked + 1;
        for (int s = 0; s < 12; s++) begin
            send_point_set(PTS_UNIFORM, $urandom_range(2, 4));
        end
        wait_for_fits();
    endtask

    task automatic test_random_sets();
        int         first;
        int         roll;
        int         count;
        t_point_mix mix;
        first = points_sent;
        while (points_sent - first < RANDOM_POINTS) begin
            set_idling($urandom_range(0, 4) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 35)      mix = PTS_UNIFORM;
            else if (roll < 50) mix = PTS_NEAR_ORIGIN;
            else if (roll < 70) mix = PTS_ON_LINE;
            else if (roll < 80) mix = PTS_SAME_X;
            else if (roll < 90) mix = PTS_STEEP;
            else                mix = PTS_CORNERS;
            roll = $urandom_range(0, 99);
            if (roll < 2)       count = $urandom_range(100, 300);
            else if (roll < 20) count = $urandom_range(7, 40);
            else                count = $urandom_range(1, 6);
            send_point_set(mix, count);
            if ($urandom_range(0, 19) == 0) begin
                wait_for_fits();
            end
        end
        wait_for_fits();
    endtask

    // result check and output stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_fits.size() == 0) begin
                $error("unexpected fit: slope %0d intercept %0d status %0d points %0d",
                       o_slope, o_intercept, o_fit_status, o_points_used);
                mismatches++;
            end else begin
                oldest_fit = expected_fits.pop_front();
                if (o_slope !== oldest_fit.slope) begin
                    $error("slope: expected %0d, got %0d", oldest_fit.slope, o_slope);
                    mismatches++;
                end
                if (o_intercept !== oldest_fit.intercept) begin
                    $error("intercept: expected %0d, got %0d", oldest_fit.intercept, o_intercept);
                    mismatches++;
                end
                if (o_fit_status !== oldest_fit.status) begin
                    $error("fit_status: expected %0d, got %0d", oldest_fit.status, o_fit_status);
                    mismatches++;
                end
                if (o_points_used !== oldest_fit.used) begin
                    $error("points_used: expected %0d, got %0d", oldest_fit.used, o_points_used);
                    mismatches++;
                end
            end
            out_wait = out_idle_on ? $urandom_range(0, 4) : 0;
        end
        if (hold_given != hold_asked) begin
            hold_given = hold_asked;
            hold_left  = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (out_wait != 0) begin
            if (o_out_valid) begin
                out_wait--;
            end
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[least_squares_line_fit] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_singular_sets();
        test_rounding_ties();
        test_saturation();
        test_output_hold();
        test_random_sets();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[least_squares_line_fit] OK");
        end else begin
            $display("[least_squares_line_fit] ERROR");
        end
        $finish;
    end

endmodule
